FILE: rtl/core/dur_pkg.sv
// ----------------------------------------------------------------------------
// dur_pkg: shared types and constants for the dual ultrasonic ranger
// Payload structs, phase encoding, register indexes and the mm conversion.
// ----------------------------------------------------------------------------
package dur_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_US = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_US = 1'd1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd6000;
   localparam logic [7:0]  TRIGGER_RESET = 8'd12;
   localparam logic [15:0] NO_DIST       = 16'hFFFF;

   // Widest tick counter supported; distance math is sized for it.
   localparam int MAX_COUNT_BITS = 24;
   localparam int SCALED_BITS    = MAX_COUNT_BITS + 5;
   localparam logic [4:0] SOUND_MUL = 5'd17;
   // floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT for all x below 2**29
   localparam int RECIP_SHIFT = 35;
   localparam logic [28:0] RECIP_100 = 29'd343597384;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_RISE = 2'd2,
      PH_HIGH = 2'd3
   } phase_type;

   typedef struct packed {
      logic req_type;
      logic echo_front;
      logic echo_rear;
   } tick_type;

   typedef struct packed {
      logic        trig_front;
      logic        trig_rear;
      logic        busy_res;
      logic        done_res;
      logic        done_sensor;
      logic [15:0] done_distance;
      logic        timed_out;
      logic [15:0] front_distance;
      logic [15:0] rear_distance;
   } result_type;

   // Echo time in microseconds to millimetres: floor(us * 17 / 100).
   function automatic logic [15:0] us_to_mm(input logic [MAX_COUNT_BITS-1:0] us);
      logic [SCALED_BITS-1:0]   scaled;
      logic [2*SCALED_BITS-1:0] product;
      logic [SCALED_BITS-1:0]   quotient;
      scaled   = SCALED_BITS'(us) * SCALED_BITS'(SOUND_MUL);
      product  = (2*SCALED_BITS)'(scaled) * (2*SCALED_BITS)'(RECIP_100);
      quotient = SCALED_BITS'(product >> RECIP_SHIFT);
      return quotient[15:0];
   endfunction

endpackage

FILE: rtl/core/dur_if.sv
// ----------------------------------------------------------------------------
// dur_if: request and response channels of the dual ultrasonic ranger
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dur_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic echo_front;
   logic echo_rear;

   modport source (output valid, output req_type, output echo_front,
                   output echo_rear, input ready);
   modport sink   (input valid, input req_type, input echo_front,
                   input echo_rear, output ready);
endinterface

interface dur_rsp_if;
   logic        valid;
   logic        ready;
   logic        trig_front;
   logic        trig_rear;
   logic        busy_res;
   logic        done_res;
   logic        done_sensor;
   logic [15:0] done_distance;
   logic        timed_out;
   logic [15:0] front_distance;
   logic [15:0] rear_distance;

   modport source (output valid, output trig_front, output trig_rear,
                   output busy_res, output done_res, output done_sensor,
                   output done_distance, output timed_out,
                   output front_distance, output rear_distance, input ready);
   modport sink   (input valid, input trig_front, input trig_rear,
                   input busy_res, input done_res, input done_sensor,
                   input done_distance, input timed_out,
                   input front_distance, input rear_distance, output ready);
endinterface

FILE: rtl/core/dual_ultrasonic_ranger_core.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_core: two-sensor ultrasonic ranging sequencer
// Each request is one microsecond tick carrying both sampled echo levels and
// an optional start flag. The core pulses the front and rear triggers in turn,
// times the echo and reports distance in mm (65535 on timeout).
//
// Channels: req_chan takes one tick per request; rsp_chan returns exactly one
// response per request with trigger levels, busy, completion info and the
// held front/rear distances. csr_we/csr_index/csr_wdata write timeout_us
// (index 0) and trigger_us (index 1); write only while the core is idle.
//
// A request passes through an input register, then the phase/count update
// and mm conversion into the response register. While responses are taken,
// one request is accepted every cycle; the mm conversion multiplier sits in
// that single stage. When rsp_chan stalls the response holds, the input
// register keeps one more request, and req_chan.ready then drops until the
// response is taken. Reset clears the valid flags of both registers, returns
// to idle with the front sensor next, and sets both held distances to 65535.
// ----------------------------------------------------------------------------
module dual_ultrasonic_ranger_core #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   dur_req_if.sink                            req_chan,
   dur_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [dur_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dur_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic              tick_valid;
   logic              tick_take;
   dur_pkg::tick_type tick;

   dur_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .tick_valid (tick_valid),
      .tick       (tick),
      .tick_take  (tick_take)
   );

   dur_step #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (tick_valid),
      .tick       (tick),
      .tick_take  (tick_take),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: rtl/core/dur_in_stage.sv
// ----------------------------------------------------------------------------
// dur_in_stage: request input register
// Captures one tick request; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module dur_in_stage (
   input  logic               clock,
   input  logic               reset,
   dur_req_if.sink            req_chan,
   output logic               tick_valid,
   output dur_pkg::tick_type  tick,
   input  logic               tick_take
);

   logic              valid_ff;
   dur_pkg::tick_type tick_ff;

   assign req_chan.ready = !valid_ff || tick_take;
   assign tick_valid     = valid_ff;
   assign tick           = tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         tick_ff.req_type   <= req_chan.req_type;
         tick_ff.echo_front <= req_chan.echo_front;
         tick_ff.echo_rear  <= req_chan.echo_rear;
      end
   end

endmodule

FILE: rtl/core/dur_step.sv
// ----------------------------------------------------------------------------
// dur_step: ranging sequencer and response register
// Advances trigger / echo-wait / echo-time phases by one tick per request.
// ----------------------------------------------------------------------------
module dur_step #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick_valid,
   input  dur_pkg::tick_type                  tick,
   output logic                               tick_take,
   input  logic                               csr_we,
   input  logic [dur_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dur_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   dur_rsp_if.source                          rsp_chan
);

   localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   logic [15:0]             timeout_ff;
   logic [7:0]              trigger_ff;
   dur_pkg::phase_type      phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] count_ff, count_in;
   logic                    sensor_ff, sensor_in;
   logic [15:0]             front_ff, front_in;
   logic [15:0]             rear_ff, rear_in;
   dur_pkg::result_type     rsp_ff, rsp_in;
   logic                    rsp_valid_ff;

   logic                    echo;
   logic                    trig;
   logic                    finish;
   logic                    tout;
   logic [15:0]             done_mm;
   logic [COUNTER_BITS-1:0] bump_base;
   logic [COUNTER_BITS-1:0] bumped;
   logic                    bump_expired;
   logic [15:0]             echo_mm;

   assign tick_take = tick_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign echo    = sensor_ff ? tick.echo_rear : tick.echo_front;
   assign echo_mm = dur_pkg::us_to_mm(dur_pkg::MAX_COUNT_BITS'(count_ff));

   // Saturating count; a rising echo restarts it from zero.
   always_comb begin
      bump_base    = (phase_ff == dur_pkg::PH_RISE && echo) ? '0 : count_ff;
      bumped       = (bump_base == CNT_MAX) ? bump_base : bump_base + 1'b1;
      bump_expired = (CMP_BITS'(bumped) >= CMP_BITS'(timeout_ff)) || (bumped == CNT_MAX);
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      trig     = 1'b0;
      finish   = 1'b0;
      tout     = 1'b0;
      done_mm  = '0;
      case (phase_ff)
         dur_pkg::PH_IDLE: begin
            if (tick.req_type) begin
               phase_in = dur_pkg::PH_TRIG;
               count_in = COUNTER_BITS'(1);
               trig     = 1'b1;
            end
         end
         dur_pkg::PH_TRIG: begin
            if (count_ff >= COUNTER_BITS'(trigger_ff)) begin
               phase_in = dur_pkg::PH_RISE;
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
               trig     = 1'b1;
            end
         end
         dur_pkg::PH_RISE: begin
            if (echo) begin
               phase_in = dur_pkg::PH_HIGH;
            end
            count_in = bumped;
            if (bump_expired) begin
               finish = 1'b1;
               tout   = 1'b1;
            end
         end
         dur_pkg::PH_HIGH: begin
            if (!echo) begin
               finish  = 1'b1;
               done_mm = echo_mm;
            end else begin
               count_in = bumped;
               if (bump_expired) begin
                  finish = 1'b1;
                  tout   = 1'b1;
               end
            end
         end
         default: begin
            phase_in = dur_pkg::PH_IDLE;
         end
      endcase

      sensor_in = sensor_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      if (tout) begin
         done_mm = dur_pkg::NO_DIST;
      end
      if (finish) begin
         if (sensor_ff) begin
            rear_in = done_mm;
         end else begin
            front_in = done_mm;
         end
         sensor_in = !sensor_ff;
         phase_in  = dur_pkg::PH_IDLE;
         count_in  = '0;
      end

      rsp_in.trig_front     = trig && !sensor_in;
      rsp_in.trig_rear      = trig && sensor_in;
      rsp_in.busy_res       = (phase_in != dur_pkg::PH_IDLE);
      rsp_in.done_res       = finish;
      rsp_in.done_sensor    = finish && sensor_ff;
      rsp_in.done_distance  = done_mm;
      rsp_in.timed_out      = tout;
      rsp_in.front_distance = front_in;
      rsp_in.rear_distance  = rear_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= dur_pkg::TIMEOUT_RESET;
         trigger_ff <= dur_pkg::TRIGGER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dur_pkg::CSR_TIMEOUT_US: timeout_ff <= csr_wdata;
            dur_pkg::CSR_TRIGGER_US: trigger_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dur_pkg::PH_IDLE;
         count_ff     <= '0;
         sensor_ff    <= 1'b0;
         front_ff     <= dur_pkg::NO_DIST;
         rear_ff      <= dur_pkg::NO_DIST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (tick_take) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            sensor_ff <= sensor_in;
            front_ff  <= front_in;
            rear_ff   <= rear_in;
         end
         if (tick_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the response until taken.
   always_ff @(posedge clock) begin
      if (tick_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.trig_front     = rsp_ff.trig_front;
   assign rsp_chan.trig_rear      = rsp_ff.trig_rear;
   assign rsp_chan.busy_res       = rsp_ff.busy_res;
   assign rsp_chan.done_res       = rsp_ff.done_res;
   assign rsp_chan.done_sensor    = rsp_ff.done_sensor;
   assign rsp_chan.done_distance  = rsp_ff.done_distance;
   assign rsp_chan.timed_out      = rsp_ff.timed_out;
   assign rsp_chan.front_distance = rsp_ff.front_distance;
   assign rsp_chan.rear_distance  = rsp_ff.rear_distance;

endmodule

FILE: tb/dual_ultrasonic_ranger_core_tb.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_core_tb: self-checking bench for the ranging core
// Streams microsecond ticks with shaped echo waveforms into the core, predicts
// every response from its own copy of the ranging sequencer, and compares each
// response field by field. Sides idle and stall at random; registers change
// between phases while the core is drained.
// ----------------------------------------------------------------------------
module dual_ultrasonic_ranger_core_tb;

   localparam int          CNT_BITS     = 16;
   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
   localparam longint      SOUND_NUM    = 17;
   localparam longint      SOUND_DEN    = 100;
   localparam int          HOLD_CYCLES  = 64;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          IDLE_PERCENT = 9;

   typedef struct packed {
      dur_pkg::phase_type  phase;
      logic [CNT_BITS-1:0] ticks;
      logic                rear_next;
      logic [15:0]         front_mm;
      logic [15:0]         rear_mm;
   } ranger_state_type;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               csr_we = 1'b0;
   logic [dur_pkg::CSR_INDEX_BITS-1:0] csr_index = dur_pkg::CSR_TIMEOUT_US;
   logic [dur_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   dur_req_if req_if();
   dur_rsp_if rsp_if();

   dual_ultrasonic_ranger_core #(
      .COUNTER_BITS(CNT_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dur_pkg::tick_type   tick_backlog[$];
   dur_pkg::result_type predicted_reports[$];
   ranger_state_type    model_state;
   ranger_state_type    plan_state;
   logic [15:0]         cfg_timeout = dur_pkg::TIMEOUT_RESET;
   logic [7:0]          cfg_trigger = dur_pkg::TRIGGER_RESET;
   dur_pkg::tick_type   offered;
   dur_pkg::result_type accepted_report;
   bit                  quiet = 1'b0;
   int                  n_accepted = 0;
   int                  n_planned = 0;
   int                  n_fail = 0;
   int                  hold_mark = -1;
   int                  last_hold = -1;
   int                  hold_left = 0;
   int                  stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Saturating tick count; true once the wait has run out.
   function automatic logic step_expired(inout logic [CNT_BITS-1:0] ticks,
                                         input logic [15:0] limit);
      if (ticks != CNT_MAX) ticks = ticks + 1'b1;
      return (ticks >= limit) || (ticks == CNT_MAX);
   endfunction

   function automatic dur_pkg::result_type ranger_tick(input ranger_state_type cur,
                                                       input dur_pkg::tick_type t,
                                                       input logic [15:0] tmo,
                                                       input logic [7:0] trg,
                                                       output ranger_state_type nxt);
      ranger_state_type    s;
      dur_pkg::result_type r;
      logic                echo;
      logic                trig;
      logic                fin;
      logic                tout;
      logic [15:0]         mm;
      s    = cur;
      echo = s.rear_next ? t.echo_rear : t.echo_front;
      trig = 1'b0;
      fin  = 1'b0;
      tout = 1'b0;
      mm   = '0;
      case (s.phase)
         dur_pkg::PH_IDLE: begin
            if (t.req_type) begin
               s.phase = dur_pkg::PH_TRIG;
               s.ticks = 1;
               trig    = 1'b1;
            end
         end
         dur_pkg::PH_TRIG: begin
            if (s.ticks >= trg) begin
               s.phase = dur_pkg::PH_RISE;
               s.ticks = '0;
            end else begin
               s.ticks = s.ticks + 1'b1;
               trig    = 1'b1;
            end
         end
         dur_pkg::PH_RISE: begin
            // the tick that sees the echo rise already counts as high time
            if (echo) begin
               s.phase = dur_pkg::PH_HIGH;
               s.ticks = '0;
            end
            if (step_expired(s.ticks, tmo)) begin
               fin  = 1'b1;
               tout = 1'b1;
            end
         end
         default: begin
            if (!echo) begin
               fin = 1'b1;
               mm  = 16'((longint'(s.ticks) * SOUND_NUM) / SOUND_DEN);
            end else if (step_expired(s.ticks, tmo)) begin
               fin  = 1'b1;
               tout = 1'b1;
            end
         end
      endcase
      r = '0;
      if (fin) begin
         if (tout) mm = dur_pkg::NO_DIST;
         r.done_res      = 1'b1;
         r.done_sensor   = s.rear_next;
         r.done_distance = mm;
         r.timed_out     = tout;
         if (s.rear_next) s.rear_mm = mm;
         else s.front_mm = mm;
         s.rear_next = !s.rear_next;
         s.phase     = dur_pkg::PH_IDLE;
         s.ticks     = '0;
      end
      r.trig_front     = trig && !s.rear_next;
      r.trig_rear      = trig && s.rear_next;
      r.busy_res       = (s.phase != dur_pkg::PH_IDLE);
      r.front_distance = s.front_mm;
      r.rear_distance  = s.rear_mm;
      nxt = s;
      return r;
   endfunction

   function automatic bit same_report(input dur_pkg::result_type a,
                                      input dur_pkg::result_type b);
      return a.trig_front === b.trig_front && a.trig_rear === b.trig_rear
         && a.busy_res === b.busy_res && a.done_res === b.done_res
         && a.done_sensor === b.done_sensor && a.done_distance === b.done_distance
         && a.timed_out === b.timed_out && a.front_distance === b.front_distance
         && a.rear_distance === b.rear_distance;
   endfunction

   function automatic string show(input dur_pkg::result_type r);
      return $sformatf("trig %b/%b busy %b done %b sensor %b dist %0d tout %b front %0d rear %0d",
                       r.trig_front, r.trig_rear, r.busy_res, r.done_res, r.done_sensor,
                       r.done_distance, r.timed_out, r.front_distance, r.rear_distance);
   endfunction

   // Queue one tick and advance the planning copy so sequences know the phase.
   task automatic add_tick(input logic req, input logic ef, input logic er);
      dur_pkg::tick_type   t;
      dur_pkg::result_type unused;
      t.req_type   = req;
      t.echo_front = ef;
      t.echo_rear  = er;
      tick_backlog.push_back(t);
      unused = ranger_tick(plan_state, t, cfg_timeout, cfg_trigger, plan_state);
      n_planned++;
   endtask

   // One measurement: echo rises after rise_wait ticks of waiting and stays high
   // for high_us microseconds; the other sensor sees noise.
   task automatic add_measurement(input int rise_wait, input int high_us,
                                  input int req_odds);
      int   rise_seen;
      int   high_seen;
      logic act;
      logic other;
      logic req;
      rise_seen = 0;
      high_seen = 0;
      add_tick(1'b1, 1'($urandom), 1'($urandom));
      while (plan_state.phase != dur_pkg::PH_IDLE) begin
         case (plan_state.phase)
            dur_pkg::PH_RISE: begin
               act = (rise_seen >= rise_wait);
               rise_seen++;
            end
            dur_pkg::PH_HIGH: begin
               act = (high_seen < high_us - 1);
               high_seen++;
            end
            default: act = 1'($urandom);
         endcase
         other = 1'($urandom);
         req   = ($urandom_range(99) < req_odds);
         if (plan_state.rear_next) add_tick(req, other, act);
         else add_tick(req, act, other);
      end
   endtask

   task automatic add_random_mix(input int n_ticks);
      int first;
      int rise;
      int high;
      first = n_planned;
      while (n_planned - first < n_ticks) begin
         case ($urandom_range(9))
            0: begin
               repeat ($urandom_range(1, 12))
                  add_tick($urandom_range(3) == 0, 1'($urandom), 1'($urandom));
               while (plan_state.phase != dur_pkg::PH_IDLE)
                  add_tick(1'b0, 1'($urandom), 1'($urandom));
            end
            1: begin
               repeat ($urandom_range(1, 4)) add_tick(1'b0, 1'($urandom), 1'($urandom));
            end
            default: begin
               rise = ($urandom_range(3) == 0) ? $urandom_range(0, int'(cfg_timeout) + 2)
                                               : $urandom_range(0, 4);
               high = $urandom_range(1, int'(cfg_timeout) + 2);
               add_measurement(rise, high, ($urandom_range(4) == 0) ? 15 : 0);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (tick_backlog.size() != 0 || req_if.valid || predicted_reports.size() != 0);
   endtask

   task automatic write_config(input logic [15:0] tmo, input logic [7:0] trg);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= dur_pkg::CSR_TIMEOUT_US;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_index <= dur_pkg::CSR_TRIGGER_US;
      csr_wdata <= dur_pkg::CSR_DATA_BITS'(trg);
      @(posedge clock);
      csr_we      <= 1'b0;
      cfg_timeout = tmo;
      cfg_trigger = trg;
   endtask

   // Driver: predict on every accepted request, then offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            accepted_report = ranger_tick(model_state, offered, cfg_timeout, cfg_trigger,
                                          model_state);
            predicted_reports.push_back(accepted_report);
            n_accepted <= n_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (tick_backlog.size() != 0
                && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered = tick_backlog.pop_front();
               req_if.valid      <= 1'b1;
               req_if.req_type   <= offered.req_type;
               req_if.echo_front <= offered.echo_front;
               req_if.echo_rear  <= offered.echo_rear;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once the accepted count reaches the armed mark.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (n_accepted == hold_mark && last_hold != hold_mark) begin
         hold_left <= HOLD_CYCLES;
         last_hold <= hold_mark;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor: compare each response with the oldest prediction.
   always @(posedge clock) begin
      dur_pkg::result_type got;
      dur_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.trig_front, rsp_if.trig_rear, rsp_if.busy_res, rsp_if.done_res,
                rsp_if.done_sensor, rsp_if.done_distance, rsp_if.timed_out,
                rsp_if.front_distance, rsp_if.rear_distance};
         if (predicted_reports.size() == 0) begin
            n_fail++;
            if (n_fail <= 10) $display("unexpected response: %s", show(got));
         end else begin
            want = predicted_reports.pop_front();
            if (!same_report(want, got)) begin
               n_fail++;
               if (n_fail <= 10) begin
                  $display("mismatch expected: %s", show(want));
                  $display("         actual:   %s", show(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("dual_ultrasonic_ranger_core_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      ranger_state_type idle_state;
      idle_state.phase     = dur_pkg::PH_IDLE;
      idle_state.ticks     = '0;
      idle_state.rear_next = 1'b0;
      idle_state.front_mm  = dur_pkg::NO_DIST;
      idle_state.rear_mm   = dur_pkg::NO_DIST;
      model_state = idle_state;
      plan_state  = idle_state;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain ticks, normal echoes, busy requests
      add_tick(1'b0, 1'b0, 1'b0);
      add_tick(1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 1'b1, 1'b0);
      add_tick(1'b0, 1'b1, 1'b1);
      add_measurement(3, 40, 0);
      add_measurement(0, 1, 100);
      add_measurement(5, 20, 10);
      wait_drained();

      // timeout 1 us: both rise and first high tick run out
      write_config(16'd1, 8'd10);
      add_measurement(0, 5, 0);
      add_measurement(4, 5, 0);
      wait_drained();

      // zero registers: one-tick trigger, immediate timeout
      write_config(16'd0, 8'd0);
      add_measurement(0, 3, 0);
      add_measurement(2, 3, 100);
      wait_drained();

      write_config(16'd3, 8'd1);
      add_measurement(0, 2, 0);
      add_measurement(1, 1, 0);
      add_measurement(1, 9, 0);
      wait_drained();

      // widest timeout with a longer trigger
      write_config(16'hFFFF, 8'd60);
      add_measurement(0, 30, 0);
      wait_drained();

      write_config(16'($urandom_range(1, 8)), 8'd10);
      hold_mark = n_accepted + 40;
      add_random_mix(80);
      wait_drained();

      write_config(16'($urandom_range(20, 60)), 8'($urandom_range(10, 40)));
      hold_mark = n_accepted + 70;
      add_random_mix(100);
      wait_drained();

      // back-to-back requests and responses, no idling on either side
      quiet = 1'b1;
      write_config(16'($urandom_range(30, 90)), 8'($urandom_range(10, 30)));
      add_random_mix(80);
      wait_drained();
      quiet = 1'b0;

      repeat (8) @(posedge clock);
      n_fail += predicted_reports.size();
      if (n_fail == 0) begin
         $display("dual_ultrasonic_ranger_core_tb OK");
      end else begin
         $display("dual_ultrasonic_ranger_core_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/dur_pkg.sv
rtl/core/dur_if.sv
rtl/core/dur_in_stage.sv
rtl/core/dur_step.sv
rtl/core/dual_ultrasonic_ranger_core.sv
tb/dual_ultrasonic_ranger_core_tb.sv
